@@ rtl/core/great_circle_distance_macros.svh @@
// assertion shorthands shared by the rtl, sampled on clk and muted while arst_n is low
`ifndef GREAT_CIRCLE_DISTANCE_MACROS_SVH
`define GREAT_CIRCLE_DISTANCE_MACROS_SVH

// condition that holds at every edge
`define GCD_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence in the same cycle
`define GCD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequence in the next cycle
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/gcdist_pkg.sv @@
`default_nettype none

package gcdist_pkg;

	localparam int FRAC_BITS        = 30;
	localparam int TAYLOR_TERMS     = 12;
	localparam int ANGLE_ITERATIONS = 24;

	// angle into the trig unit: half-units of 1e-7 degree, signed
	localparam int ANG_W  = 34;
	// signed sine or cosine, Q30
	localparam int TRIG_W = 32;

	localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;

	// atan(2^-i) in Q30, rounded
	localparam logic [29:0] ATAN_TAB [0:ANGLE_ITERATIONS-1] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
		30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
		30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
		30'd262144,    30'd131072,    30'd65536,     30'd32768,
		30'd16384,     30'd8192,      30'd4096,      30'd2048,
		30'd1024,      30'd512,       30'd256,       30'd128
	};

endpackage

`default_nettype wire

@@ rtl/core/gcdist_sincos.sv @@
`default_nettype none

// sine or cosine of an angle in half-units, 43 register stages
module gcdist_sincos
	import gcdist_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [ANG_W-1:0]  angle,
	input  wire logic                     want_cos,
	output logic signed [TRIG_W-1:0]      trig
);

	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

	typedef struct packed {
		logic [29:0] t;
		logic [29:0] t2;
		logic        neg;
		quad_t       quad;
	} ctx_t;

	localparam logic signed [34:0] CIRCLE  = 35'sd7200000000;
	localparam logic [32:0]        QUARTER = 33'd1800000000;
	localparam logic [32:0]        H1 = 33'd900000000;
	localparam logic [32:0]        H3 = 33'd2700000000;
	localparam logic [32:0]        H5 = 33'd4500000000;
	localparam logic [32:0]        H7 = 33'd6300000000;
	// pi / 3.6e9 in Q64
	localparam logic [33:0]        RAD_Q64 = 34'd16097821018;

	// reduce modulo a full circle
	logic signed [34:0] wrap;
	logic [32:0]        u_s1;

	assign wrap = angle[ANG_W-1] ? (35'(angle) + CIRCLE) : 35'(angle);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= wrap[32:0];
		end
	end

	// quadrant and residue
	logic [32:0]        qoff;
	quad_t              quad;
	logic signed [34:0] res;
	logic [29:0]        mag_s2;
	logic               neg_s2;
	quad_t              quad_s2;

	always_comb begin
		if (u_s1 < H1) begin
			qoff = '0;
			quad = QUAD_0;
		end else if (u_s1 < H3) begin
			qoff = QUARTER;
			quad = QUAD_1;
		end else if (u_s1 < H5) begin
			qoff = 33'(QUARTER * 2);
			quad = QUAD_2;
		end else if (u_s1 < H7) begin
			qoff = 33'(QUARTER * 3);
			quad = QUAD_3;
		end else begin
			qoff = 33'(QUARTER * 4);
			quad = QUAD_0;
		end
		res = $signed({2'b00, u_s1}) - $signed({2'b00, qoff});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2  <= res[34];
			mag_s2  <= res[34] ? 30'(-res) : res[29:0];
			quad_s2 <= quad;
		end
	end

	// residue to radians
	logic [63:0] prod_s3;
	logic        neg_s3;
	quad_t       quad_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= mag_s2 * RAD_Q64;
			neg_s3  <= neg_s2;
			quad_s3 <= quad_s2;
		end
	end

	logic [64:0] prod_rnd;
	logic [29:0] t_s4;
	logic        neg_s4;
	quad_t       quad_s4;

	assign prod_rnd = {1'b0, prod_s3} + (65'd1 << (63 - FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4    <= prod_rnd[63:64-FRAC_BITS];
			neg_s4  <= neg_s3;
			quad_s4 <= quad_s3;
		end
	end

	logic [59:0] tt;
	ctx_t        ctx_s5;

	assign tt = t_s4 * t_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5.t    <= t_s4;
			ctx_s5.t2   <= tt[59:30];
			ctx_s5.neg  <= neg_s4;
			ctx_s5.quad <= quad_s4;
		end
	end

	// taylor terms, highest first: multiply, scaled quotient, correction
	ctx_t        ctx_ta [0:TAYLOR_TERMS-1];
	ctx_t        ctx_tb [0:TAYLOR_TERMS-1];
	ctx_t        ctx_tc [0:TAYLOR_TERMS-1];
	logic [30:0] ps_ta  [0:TAYLOR_TERMS-1];
	logic [30:0] pc_ta  [0:TAYLOR_TERMS-1];
	logic [30:0] ps_tb  [0:TAYLOR_TERMS-1];
	logic [30:0] pc_tb  [0:TAYLOR_TERMS-1];
	logic [30:0] qs_tb  [0:TAYLOR_TERMS-1];
	logic [30:0] qc_tb  [0:TAYLOR_TERMS-1];
	logic [30:0] s_tc   [0:TAYLOR_TERMS-1];
	logic [30:0] c_tc   [0:TAYLOR_TERMS-1];

	for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_term
		localparam int          K    = TAYLOR_TERMS - j;
		localparam logic [31:0] DS   = 32'((2*K) * (2*K+1));
		localparam logic [31:0] DC   = 32'((2*K-1) * (2*K));
		localparam logic [31:0] RS   = 32'((64'd1 << 32) / DS);
		localparam logic [31:0] RC   = 32'((64'd1 << 32) / DC);

		ctx_t        ctx_in;
		logic [30:0] s_in;
		logic [30:0] c_in;
		logic [60:0] ms;
		logic [60:0] mc;
		logic [62:0] ns;
		logic [62:0] nc;
		logic [31:0] rem_s;
		logic [31:0] rem_c;
		logic [30:0] quo_s;
		logic [30:0] quo_c;

		if (j == 0) begin : g_first
			assign ctx_in = ctx_s5;
			assign s_in   = ONE_Q;
			assign c_in   = ONE_Q;
		end else begin : g_next
			assign ctx_in = ctx_tc[j-1];
			assign s_in   = s_tc[j-1];
			assign c_in   = c_tc[j-1];
		end

		assign ms = s_in * ctx_in.t2;
		assign mc = c_in * ctx_in.t2;

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_ta[j] <= ctx_in;
				ps_ta[j]  <= ms[60:30];
				pc_ta[j]  <= mc[60:30];
			end
		end

		assign ns = ps_ta[j] * RS;
		assign nc = pc_ta[j] * RC;

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_tb[j] <= ctx_ta[j];
				ps_tb[j]  <= ps_ta[j];
				pc_tb[j]  <= pc_ta[j];
				qs_tb[j]  <= ns[62:32];
				qc_tb[j]  <= nc[62:32];
			end
		end

		// quotient estimate is exact or one short
		always_comb begin
			rem_s = {1'b0, ps_tb[j]} - 32'(qs_tb[j] * DS);
			rem_c = {1'b0, pc_tb[j]} - 32'(qc_tb[j] * DC);
			quo_s = (rem_s >= DS) ? (qs_tb[j] + 31'd1) : qs_tb[j];
			quo_c = (rem_c >= DC) ? (qc_tb[j] + 31'd1) : qc_tb[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_tc[j] <= ctx_tb[j];
				s_tc[j]   <= ONE_Q - quo_s;
				c_tc[j]   <= ONE_Q - quo_c;
			end
		end
	end

	// sine of the residue
	logic [60:0] st_prod;
	logic [30:0] sr_s42;
	logic [30:0] cr_s42;
	logic        neg_s42;
	quad_t       quad_s42;

	assign st_prod = s_tc[TAYLOR_TERMS-1] * ctx_tc[TAYLOR_TERMS-1].t;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s42   <= st_prod[60:30];
			cr_s42   <= c_tc[TAYLOR_TERMS-1];
			neg_s42  <= ctx_tc[TAYLOR_TERMS-1].neg;
			quad_s42 <= ctx_tc[TAYLOR_TERMS-1].quad;
		end
	end

	// quadrant mapping
	logic signed [TRIG_W-1:0] srs;
	logic signed [TRIG_W-1:0] crs;
	logic signed [TRIG_W-1:0] sn;
	logic signed [TRIG_W-1:0] cs;

	always_comb begin
		crs = $signed({1'b0, cr_s42});
		srs = neg_s42 ? -$signed({1'b0, sr_s42}) : $signed({1'b0, sr_s42});
		case (quad_s42)
			QUAD_0: begin
				sn = srs;
				cs = crs;
			end
			QUAD_1: begin
				sn = crs;
				cs = -srs;
			end
			QUAD_2: begin
				sn = -srs;
				cs = -crs;
			end
			default: begin
				sn = -crs;
				cs = srs;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig <= want_cos ? cs : sn;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/great_circle_distance.sv @@
// great-circle distance between two points, haversine formula in fixed point
//
// input stream (s_axis): one request per beat, two points as latitude and
// longitude in signed units of 1e-7 degree; output stream (m_axis): one
// distance in millimetres per request, in request order.
// apb port: register 0 is the sphere radius in metres (reset 6378137).
// write it only while no request is in flight.
//
// throughput: one request per cycle while the pipeline is not frozen; every
// stage of the trig units, the two square roots and the arctangent rotations
// is its own register stage.
//
// reset clears all valid bits and loads the radius reset value; nothing is
// in flight after it.
// when m_axis_tready is low the result stays put and the next one lands in a
// skid register; only when that is also full does the whole pipeline freeze
// and s_axis_tready drop. nothing is dropped or repeated.
`default_nettype none
`include "great_circle_distance_macros.svh"

module great_circle_distance
	import gcdist_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94], zero pad
	input  wire logic [127:0] s_axis_tdata,

	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// distance_mm[34:0], zero pad
	output logic [39:0]       m_axis_tdata,

	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SC_LAT     = 43;
	localparam int SQ_STAGES  = (FRAC_BITS + 2) / 2;
	localparam int CR_STAGES  = (ANGLE_ITERATIONS + 1) / 2;
	localparam int ST_TRIG    = 1 + SC_LAT;
	localparam int ST_H       = ST_TRIG + 3;
	localparam int ST_SQ      = ST_H + SQ_STAGES;
	localparam int PIPE_LEN   = ST_SQ + CR_STAGES + 2;

	localparam logic         REG_RADIUS   = 1'b0;
	localparam logic [22:0]  RADIUS_RESET = 23'd6378137;

	typedef struct packed {
		logic [34:0] rem;
		logic [30:0] root;
	} sq_t;

	// one restoring square-root digit
	function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
		sq_t         nxt;
		logic [34:0] remn;
		logic [34:0] trial;
		remn  = {cur.rem[32:0], pair};
		trial = {2'b00, cur.root, 2'b01};
		if (remn >= trial) begin
			nxt.rem  = remn - trial;
			nxt.root = {cur.root[29:0], 1'b1};
		end else begin
			nxt.rem  = remn;
			nxt.root = {cur.root[29:0], 1'b0};
		end
		return nxt;
	endfunction

	// ---------------- configuration ----------------
	logic [22:0] earth_radius_q;
	logic [32:0] radius_mm_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_RADIUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			earth_radius_q <= RADIUS_RESET;
			radius_mm_q    <= 33'(RADIUS_RESET) * 33'd1000;
		end else if (cfg_wr) begin
			earth_radius_q <= pwdata[22:0];
			radius_mm_q    <= 33'(pwdata[22:0]) * 33'd1000;
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RADIUS: prdata = {9'd0, earth_radius_q};
			default:    prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic                vld_s [1:PIPE_LEN];
	logic                pipe_en;
	logic                skid_v_q;
	logic                out_v_q;
	logic [34:0]         skid_q;
	logic [34:0]         out_q;
	logic [34:0]         dist_s77;
	logic                push;
	logic                out_free;

	// pipeline freezes only when the skid register is occupied
	assign pipe_en       = !skid_v_q;
	assign s_axis_tready = pipe_en;
	assign push          = vld_s[PIPE_LEN] && pipe_en;
	assign out_free      = !out_v_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_LEN; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (pipe_en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= PIPE_LEN; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_free) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_free) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_free) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_free) begin
				out_q <= dist_s77;
			end else begin
				skid_q <= dist_s77;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, out_q};

	// ---------------- stage 1: angle differences ----------------
	logic signed [30:0]      lat_a;
	logic signed [31:0]      lon_a;
	logic signed [30:0]      lat_b;
	logic signed [31:0]      lon_b;
	logic signed [ANG_W-1:0] dlat_s1;
	logic signed [ANG_W-1:0] dlon_s1;
	logic signed [ANG_W-1:0] dbl_a_s1;
	logic signed [ANG_W-1:0] dbl_b_s1;

	assign lat_a = s_axis_tdata[30:0];
	assign lon_a = s_axis_tdata[62:31];
	assign lat_b = s_axis_tdata[93:63];
	assign lon_b = s_axis_tdata[125:94];

	// latitudes are doubled so all four angles share the half-unit scale
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dlat_s1  <= ANG_W'(lat_a) - ANG_W'(lat_b);
			dlon_s1  <= ANG_W'(lon_a) - ANG_W'(lon_b);
			dbl_a_s1 <= ANG_W'(lat_a) <<< 1;
			dbl_b_s1 <= ANG_W'(lat_b) <<< 1;
		end
	end

	// ---------------- trig units ----------------
	logic signed [TRIG_W-1:0] sin_dlat;
	logic signed [TRIG_W-1:0] sin_dlon;
	logic signed [TRIG_W-1:0] cos_a;
	logic signed [TRIG_W-1:0] cos_b;

	gcdist_sincos u_sin_dlat (
		.clk      (clk),
		.en       (pipe_en),
		.angle    (dlat_s1),
		.want_cos (1'b0),
		.trig     (sin_dlat)
	);

	gcdist_sincos u_sin_dlon (
		.clk      (clk),
		.en       (pipe_en),
		.angle    (dlon_s1),
		.want_cos (1'b0),
		.trig     (sin_dlon)
	);

	gcdist_sincos u_cos_a (
		.clk      (clk),
		.en       (pipe_en),
		.angle    (dbl_a_s1),
		.want_cos (1'b1),
		.trig     (cos_a)
	);

	gcdist_sincos u_cos_b (
		.clk      (clk),
		.en       (pipe_en),
		.angle    (dbl_b_s1),
		.want_cos (1'b1),
		.trig     (cos_b)
	);

	// ---------------- haversine ----------------
	logic [30:0] ma;
	logic [30:0] mb;
	logic [30:0] m1;
	logic [30:0] m2;
	logic [61:0] paa_full;
	logic [61:0] pbb_full;
	logic [61:0] p12_full;
	logic [30:0] paa_s45;
	logic [30:0] pbb_s45;
	logic [30:0] p12_s45;
	logic        sgn_s45;

	assign ma = sin_dlat[TRIG_W-1] ? 31'(-sin_dlat) : sin_dlat[30:0];
	assign mb = sin_dlon[TRIG_W-1] ? 31'(-sin_dlon) : sin_dlon[30:0];
	assign m1 = cos_a[TRIG_W-1]    ? 31'(-cos_a)    : cos_a[30:0];
	assign m2 = cos_b[TRIG_W-1]    ? 31'(-cos_b)    : cos_b[30:0];

	assign paa_full = ma * ma;
	assign pbb_full = mb * mb;
	assign p12_full = m1 * m2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			paa_s45 <= paa_full[60:30];
			pbb_s45 <= pbb_full[60:30];
			p12_s45 <= p12_full[60:30];
			sgn_s45 <= cos_a[TRIG_W-1] ^ cos_b[TRIG_W-1];
		end
	end

	logic [61:0] term_full;
	logic [30:0] term_s46;
	logic [30:0] paa_s46;
	logic        sgn_s46;

	assign term_full = p12_s45 * pbb_s45;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			term_s46 <= term_full[60:30];
			paa_s46  <= paa_s45;
			sgn_s46  <= sgn_s45;
		end
	end

	// h clamped to [0, 1], and 1 - h for the cosine side
	logic signed [32:0] h_sum;
	logic [30:0]        h_clamp;
	logic [30:0]        h_s47;
	logic [30:0]        hc_s47;

	always_comb begin
		if (sgn_s46) begin
			h_sum = $signed({2'b00, paa_s46}) - $signed({2'b00, term_s46});
		end else begin
			h_sum = $signed({2'b00, paa_s46}) + $signed({2'b00, term_s46});
		end
		if (h_sum[32]) begin
			h_clamp = '0;
		end else if (h_sum > $signed({2'b00, ONE_Q})) begin
			h_clamp = ONE_Q;
		end else begin
			h_clamp = h_sum[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			h_s47  <= h_clamp;
			hc_s47 <= ONE_Q - h_clamp;
		end
	end

	// square roots: two digits a stage, one digit in the last stage
	sq_t         sqy_s [0:SQ_STAGES];
	sq_t         sqx_s [0:SQ_STAGES];
	logic [30:0] hy_s  [0:SQ_STAGES];
	logic [30:0] hx_s  [0:SQ_STAGES];

	assign sqy_s[0] = '0;
	assign sqx_s[0] = '0;
	assign hy_s[0]  = h_s47;
	assign hx_s[0]  = hc_s47;

	for (genvar st = 0; st < SQ_STAGES; st++) begin : g_sqrt
		localparam int J0 = FRAC_BITS - 2*st;
		localparam int J1 = J0 - 1;

		logic [61:0] vy;
		logic [61:0] vx;
		sq_t         y1;
		sq_t         x1;
		sq_t         y2;
		sq_t         x2;

		// radicand is h scaled up by 2^30
		assign vy = {1'b0, hy_s[st], 30'd0};
		assign vx = {1'b0, hx_s[st], 30'd0};
		assign y1 = sqrt_step(sqy_s[st], vy[2*J0+1 -: 2]);
		assign x1 = sqrt_step(sqx_s[st], vx[2*J0+1 -: 2]);

		if (J1 >= 0) begin : g_two
			assign y2 = sqrt_step(y1, vy[2*J1+1 -: 2]);
			assign x2 = sqrt_step(x1, vx[2*J1+1 -: 2]);
		end else begin : g_one
			assign y2 = y1;
			assign x2 = x1;
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				sqy_s[st+1] <= y2;
				sqx_s[st+1] <= x2;
				hy_s[st+1]  <= hy_s[st];
				hx_s[st+1]  <= hx_s[st];
			end
		end
	end

	// ---------------- arctangent by vectoring rotations ----------------
	logic signed [33:0] cx_s [0:CR_STAGES];
	logic signed [33:0] cy_s [0:CR_STAGES];
	logic signed [32:0] cz_s [0:CR_STAGES];

	assign cx_s[0] = $signed({3'b000, sqx_s[SQ_STAGES].root});
	assign cy_s[0] = $signed({3'b000, sqy_s[SQ_STAGES].root});
	assign cz_s[0] = '0;

	for (genvar st = 0; st < CR_STAGES; st++) begin : g_cordic
		logic signed [33:0] x_n;
		logic signed [33:0] y_n;
		logic signed [32:0] z_n;

		always_comb begin
			logic signed [33:0] xs;
			logic signed [33:0] ys;
			x_n = cx_s[st];
			y_n = cy_s[st];
			z_n = cz_s[st];
			for (int k = 0; k < 2; k++) begin
				if (2*st + k < ANGLE_ITERATIONS) begin
					xs = x_n >>> (2*st + k);
					ys = y_n >>> (2*st + k);
					if (!y_n[33]) begin
						x_n = x_n + ys;
						y_n = y_n - xs;
						z_n = z_n + $signed({3'b000, ATAN_TAB[2*st + k]});
					end else begin
						x_n = x_n - ys;
						y_n = y_n + xs;
						z_n = z_n - $signed({3'b000, ATAN_TAB[2*st + k]});
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				cx_s[st+1] <= x_n;
				cy_s[st+1] <= y_n;
				cz_s[st+1] <= z_n;
			end
		end
	end

	// ---------------- scale by radius ----------------
	// central angle is 2z, product split in two halves over two stages
	logic [31:0] z_pos;
	logic [32:0] central;
	logic [49:0] plo_s76;
	logic [48:0] phi_s76;

	assign z_pos   = cz_s[CR_STAGES][32] ? 32'd0 : cz_s[CR_STAGES][31:0];
	assign central = {z_pos, 1'b0};

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			plo_s76 <= central[16:0] * radius_mm_q;
			phi_s76 <= central[32:17] * radius_mm_q;
		end
	end

	logic [66:0] dist_sum;

	assign dist_sum = 67'(plo_s76) + {1'b0, phi_s76, 17'd0}
		+ (67'd1 << (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dist_s77 <= dist_sum[FRAC_BITS+34:FRAC_BITS];
		end
	end

	// ---------------- checks ----------------
	`GCD_ASSERT_IMPLIES(a_skid_behind_out, skid_v_q, out_v_q, "skid holds a result while output is empty")
	`GCD_ASSERT_NEXT(a_freeze_holds, !pipe_en, $stable(vld_s[PIPE_LEN]), "pipeline moved while frozen")
	`GCD_ASSERT_HOLDS(a_radius_mm, radius_mm_q == 33'(earth_radius_q) * 33'd1000, "radius copies disagree")

endmodule

`default_nettype wire

@@ verif/tb_great_circle_distance.sv @@
`timescale 1ns / 100ps

// scoreboard for the distance stream: predicts each request's distance and
// keeps the predictions in request order
class distance_scoreboard;
	longint unsigned radius_m;
	bit [34:0]       pending_mm[$];
	int              fail_count;

	function new();
		radius_m   = 64'd6378137;
		fail_count = 0;
	endfunction

	// truncating q30 product
	function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
		bit [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[93:30];
	endfunction

	// sine and cosine of an angle in half-units of 1e-7 degree
	function automatic void trig(longint v, output longint sn, output longint cs);
		longint u, q, r, sr, cr;
		longint unsigned mag, t, t2, s, c, k;
		bit neg;
		u = v % 64'sd7200000000;
		if (u < 0)
			u += 64'sd7200000000;
		q   = (u + 64'sd900000000) / 64'sd1800000000;
		r   = u - q * 64'sd1800000000;
		neg = r < 0;
		mag = neg ? -r : r;
		t   = (mag * 64'd16097821018 + (64'd1 << 33)) >> 34;
		t2  = qmul(t, t);
		s   = 64'd1 << 30;
		c   = 64'd1 << 30;
		for (k = 12; k >= 1; k--) begin
			s = (64'd1 << 30) - qmul(s, t2) / ((2 * k) * (2 * k + 1));
			c = (64'd1 << 30) - qmul(c, t2) / ((2 * k - 1) * (2 * k));
		end
		sr = qmul(s, t);
		cr = c;
		if (neg)
			sr = -sr;
		case (q & 3)
			0: begin sn = sr;  cs = cr;  end
			1: begin sn = cr;  cs = -sr; end
			2: begin sn = -sr; cs = -cr; end
			default: begin sn = -cr; cs = sr; end
		endcase
	endfunction

	// floor(sqrt(h * 2^30)), two bits per step
	function automatic longint unsigned root_q(longint unsigned h);
		longint unsigned rem, root, trial;
		int j, b;
		bit [1:0] pair;
		rem  = 0;
		root = 0;
		for (j = 30; j >= 0; j--) begin
			pair = 0;
			for (b = 2 * j + 1; b >= 2 * j; b--)
				pair = {pair[0], (b >= 30) ? h[b - 30] : 1'b0};
			rem   = (rem << 2) | pair;
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// atan(2^-i) in q30 from a q62 series
	function automatic longint atan_step(int i);
		longint unsigned acc, term;
		int k;
		if (i == 0) begin
			acc = 64'd3622009729038561421;
		end else begin
			acc = 0;
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
				if (k & 1)
					acc -= term;
				else
					acc += term;
			end
		end
		return (acc + (64'd1 << 31)) >> 32;
	endfunction

	function automatic bit [34:0] distance(bit [127:0] req);
		longint lat_a, lon_a, lat_b, lon_b, s_dlat, s_dlon, c_a, c_b, dummy;
		longint term, h, x, y, z, xs, ys, a;
		longint unsigned ma, mb, m1, m2;
		bit [127:0] p;
		lat_a = longint'($signed(req[30:0]));
		lon_a = longint'($signed(req[62:31]));
		lat_b = longint'($signed(req[93:63]));
		lon_b = longint'($signed(req[125:94]));
		trig(lat_a - lat_b, s_dlat, dummy);
		trig(lon_a - lon_b, s_dlon, dummy);
		trig(2 * lat_a, dummy, c_a);
		trig(2 * lat_b, dummy, c_b);
		ma = s_dlat < 0 ? -s_dlat : s_dlat;
		mb = s_dlon < 0 ? -s_dlon : s_dlon;
		m1 = c_a < 0 ? -c_a : c_a;
		m2 = c_b < 0 ? -c_b : c_b;
		term = qmul(qmul(m1, m2), qmul(mb, mb));
		if ((c_a < 0) != (c_b < 0))
			term = -term;
		h = longint'(qmul(ma, ma)) + term;
		if (h < 0)
			h = 0;
		if (h > (64'sd1 << 30))
			h = 64'sd1 << 30;
		y = root_q(h);
		x = root_q((64'sd1 << 30) - h);
		z = 0;
		for (int i = 0; i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			a  = atan_step(i);
			if (y >= 0) begin
				x += ys; y -= xs; z += a;
			end else begin
				x -= ys; y += xs; z -= a;
			end
		end
		if (z < 0)
			z = 0;
		p = {64'd0, 64'(z) * 2} * {64'd0, radius_m * 1000} + (128'd1 << 29);
		return p[64:30];
	endfunction

	function void note_request(bit [127:0] req);
		pending_mm.push_back(distance(req));
	endfunction

	function void check_result(bit [34:0] got);
		bit [34:0] want;
		if (pending_mm.size() == 0) begin
			$error("distance_mm: no request outstanding, actual %0d", got);
			fail_count++;
			return;
		end
		want = pending_mm.pop_front();
		if (want !== got) begin
			$error("distance_mm: expected %0d, actual %0d", want, got);
			fail_count++;
		end
	endfunction
endclass

module tb_great_circle_distance;
	import gcdist_pkg::*;

	localparam int LATENCY = 77;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94], zero pad
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// distance_mm[34:0], zero pad
	logic [39:0]  m_axis_tdata;
	logic         psel, penable, pwrite, pready;
	logic [2:0]   paddr;
	logic [31:0]  pwdata, prdata;

	distance_scoreboard sb;

	// sender and receiver idling controls
	bit calm;          // no idling on either side
	bit hold_request;  // receiver holds off for a long stretch
	bit hold_done;

	great_circle_distance dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// receiver: each accepted result is checked here; the random stalls and one long hold-off are driven below
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[34:0]);
	end

	initial begin
		m_axis_tready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				// long hold-off so the pipeline and skid fill and s_axis_tready drops
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end
			m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
		end
	end

	// one request; valid stays high straight into the next one unless idling
	task automatic send_request(bit [127:0] req);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(req);
		if (!calm) begin
			while ($urandom_range(99) < 16) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	function automatic bit [127:0] pack_points(int lat_a, int lon_a, int lat_b, int lon_b);
		return {2'b00, 32'(lon_b), 31'(lat_b), 32'(lon_a), 31'(lat_a)};
	endfunction

	// in-range point pair, or raw bits over the whole field widths
	function automatic bit [127:0] random_points();
		bit [127:0] r;
		if ($urandom_range(9) < 2) begin
			r = {$urandom(), $urandom(), $urandom(), $urandom()};
			r[127:126] = 2'b00;
			return r;
		end
		return pack_points($urandom_range(1800000000) - 900000000,
			$urandom() % 32'd3600000001 - 32'd1800000000,
			$urandom_range(1800000000) - 900000000,
			$urandom() % 32'd3600000001 - 32'd1800000000);
	endfunction

	// let the pipeline empty; the extra latency wait is harmless with one result per request
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_mm.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_radius(bit [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'd0;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.radius_m = value[22:0];
	endtask

	task automatic random_burst(int count);
		for (int i = 0; i < count; i++)
			send_request(random_points());
	endtask

	initial begin
		bit [31:0] radii[5];
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, coincident and antipodal points, out-of-range latitude
		send_request(pack_points(0, 0, 0, 0));
		send_request(pack_points(900000000, 0, -900000000, 0));
		send_request(pack_points(-900000000, 1800000000, 900000000, -1800000000));
		send_request(pack_points(0, 0, 0, 1800000000));
		send_request(pack_points(0, -1800000000, 0, 1800000000));
		send_request(pack_points(0, 2147483647, 0, 32'sh80000000));
		send_request(pack_points(1073741823, 0, -1073741824, 0));
		send_request(pack_points(-1073741824, 2147483647, -1073741824, 2147483647));
		send_request(pack_points(900000000, 123, 900000000, -1800000000));
		send_request(pack_points(485000000, 22000000, 485000001, 22000000));
		send_request(pack_points(123456789, -987654321, 123456789, -987654321));
		send_request(pack_points(450000000, 900000000, -450000000, -900000000));
		send_request(pack_points(1, 0, 0, 1));
		send_request(pack_points(-899999999, 1799999999, 899999999, -1799999999));
		send_request(pack_points(0, 0, 0, 1800000000));
		send_request(pack_points(1000000000, 0, 0, 0));
		send_request(pack_points(-1000000000, 0, 1000000000, 0));
		random_burst(150);

		// long receiver hold-off while the sender keeps offering requests
		calm = 1'b1;
		hold_request = 1'b1;
		random_burst(300);
		hold_request = 1'b0;
		calm = 1'b0;
		// sender pauses until every result is in
		s_axis_tvalid <= 1'b0;
		while (sb.pending_mm.size() != 0)
			@(posedge clk);
		random_burst(100);
		drain();

		radii[0] = 32'd6000000;
		radii[1] = 32'd7000000;
		radii[2] = 32'd0;
		radii[3] = 32'h7fffff;
		radii[4] = $urandom_range(7000000, 6000000);
		foreach (radii[i]) begin
			write_radius(radii[i]);
			send_request(pack_points(900000000, 0, -900000000, 0));
			send_request(pack_points(0, 0, 0, 0));
			random_burst(160);
			drain();
		end

		if (sb.fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// timeout
	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
